/* rtl/core/ura_pkg.sv */
// Shared constants and helpers for the unsigned radix-to-ASCII converter.
// No dependencies; the divider and the converter import this package.
package ura_pkg;

  // Default width of the converted value.
  localparam int VALUE_BITS_DEF = 32;

  // Quotient bits the shared divider resolves per clock.
  localparam int STEP_BITS = 4;

  // Accepted radix range.
  localparam logic [4:0] BASE_MIN = 5'd2;
  localparam logic [4:0] BASE_MAX = 5'd16;

  // Characters used by the converter.
  localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CHAR_X_LOWER = 8'h78;  // 'x'
  localparam logic [7:0] CHAR_A_UPPER = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_A_LOWER = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_NONE    = 8'h00;

  // Map one digit to its ASCII character in the chosen letter case.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = CHAR_ZERO + {4'd0, d};
    end else if (upper) begin
      ch = CHAR_A_UPPER + {4'd0, d} - 8'd10;
    end else begin
      ch = CHAR_A_LOWER + {4'd0, d} - 8'd10;
    end
    return ch;
  endfunction

endpackage

/* rtl/core/ura_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; sized by its WIDTH and DEPTH parameters.
module ura_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/ura_div.sv */
// Iterative restoring divider: value by a 5-bit radix, STEP_BITS quotient bits a clock.
// Depends on ura_pkg for STEP_BITS and the default value width.
module ura_div import ura_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [4:0]            divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [3:0]            remainder
);

  localparam int DIV_W      = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int STEPS      = DIV_W / STEP_BITS;
  localparam int STEP_CNT_W = $clog2(STEPS + 1);

  logic [DIV_W-1:0]      shreg;
  logic [DIV_W-1:0]      shreg_next;
  logic [3:0]            rem;
  logic [3:0]            rem_next;
  logic [STEP_CNT_W-1:0] step_cnt;
  logic                  busy;

  // STEP_BITS dependent compare-and-subtract steps on the narrow partial remainder.
  always_comb begin
    logic [4:0] trial;
    logic       ge;
    shreg_next = shreg;
    rem_next   = rem;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial      = {rem_next, shreg_next[DIV_W-1]};
      ge         = (trial >= divisor);
      shreg_next = {shreg_next[DIV_W-2:0], ge};
      rem_next   = ge ? 4'(trial - divisor) : trial[3:0];
    end
  end

  // Sequencing of the division steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step_cnt <= STEP_CNT_W'(STEPS);
      end else if (busy) begin
        step_cnt <= step_cnt - STEP_CNT_W'(1);
        if (step_cnt == STEP_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= DIV_W'(dividend);
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg_next;
      rem   <= rem_next;
    end
  end

  assign quotient  = shreg[VALUE_BITS-1:0];
  assign remainder = rem;

endmodule

/* rtl/core/unsigned_radix_to_ascii.sv */
// Unsigned radix-to-ASCII converter, one request at a time.
// Each digit comes from the shared divider, and each character passes through the digit
// RAM and the output register. Zero and bad radix give a single result without division.
// Synchronous active-high reset returns the sequencer to idle with no output.
module unsigned_radix_to_ascii import ura_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [4:0]            base,
  input  logic                  upper_case,
  input  logic                  add_prefix,
  input  logic                  precision_zero,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output logic [7:0]            character,
  output logic                  last,
  output logic                  empty_res,
  output logic                  bad_base
);

  localparam int CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int ADDR_W = $clog2(VALUE_BITS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_START,
    S_DIV_RUN,
    S_PFX_ZERO,
    S_PFX_X,
    S_READ,
    S_LOAD,
    S_EMIT,
    S_SINGLE
  } state_t;

  state_t                state;
  logic [VALUE_BITS-1:0] remaining_value;
  logic [CNT_W-1:0]      digit_count;
  logic [CNT_W-1:0]      digit_count_next;
  logic [CNT_W-1:0]      emit_index;
  logic [CNT_W-1:0]      emit_pos;
  logic [4:0]            base_q;
  logic                  upper_q;
  logic                  prefix_q;

  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [3:0]            div_rem;
  logic                  ram_we;
  logic                  ram_re;
  logic [3:0]            ram_rdata;

  logic                  req_fire;
  logic                  rsp_fire;
  logic                  base_ok;

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign rsp_fire  = rsp_valid && rsp_ready;
  assign base_ok   = (base >= BASE_MIN) && (base <= BASE_MAX);

  assign div_start        = (state == S_DIV_START);
  assign ram_we           = (state == S_DIV_RUN) && div_done;
  assign ram_re           = (state == S_READ);
  assign digit_count_next = digit_count + CNT_W'(1);
  assign emit_pos         = digit_count - CNT_W'(1) - emit_index;

  // Shared divider produces one digit per pass.
  ura_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (remaining_value),
    .divisor  (base_q),
    .done     (div_done),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  // Digit store, least significant digit at address zero.
  ura_ram #(
    .WIDTH(4),
    .DEPTH(VALUE_BITS)
  ) u_digits (
    .clk  (clk),
    .we   (ram_we),
    .waddr(digit_count[ADDR_W-1:0]),
    .wdata(div_rem),
    .re   (ram_re),
    .raddr(emit_pos[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  // Sequencer with the registered result outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      rsp_valid       <= 1'b0;
      remaining_value <= '0;
      digit_count     <= '0;
      emit_index      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            base_q   <= base;
            upper_q  <= upper_case;
            prefix_q <= add_prefix;
            if (!base_ok) begin
              // Bad radix: one flagged result; the remaining value and digit counters stay untouched.
              rsp_valid <= 1'b1;
              character <= CHAR_NONE;
              last      <= 1'b1;
              empty_res <= 1'b0;
              bad_base  <= 1'b1;
              state     <= S_SINGLE;
            end else if (value == '0) begin
              // Zero gives a lone '0' or an empty result, never a prefix.
              remaining_value <= '0;
              digit_count     <= '0;
              emit_index      <= '0;
              rsp_valid       <= 1'b1;
              character       <= precision_zero ? CHAR_NONE : CHAR_ZERO;
              last            <= 1'b1;
              empty_res       <= precision_zero;
              bad_base        <= 1'b0;
              state           <= S_SINGLE;
            end else begin
              remaining_value <= value;
              digit_count     <= '0;
              emit_index      <= '0;
              state           <= S_DIV_START;
            end
          end
        end
        S_DIV_START: begin
          state <= S_DIV_RUN;
        end
        S_DIV_RUN: begin
          if (div_done) begin
            remaining_value <= div_quot;
            digit_count     <= digit_count_next;
            if (div_quot == '0 || digit_count_next == CNT_W'(VALUE_BITS)) begin
              if (prefix_q) begin
                rsp_valid <= 1'b1;
                character <= CHAR_ZERO;
                last      <= 1'b0;
                empty_res <= 1'b0;
                bad_base  <= 1'b0;
                state     <= S_PFX_ZERO;
              end else begin
                state <= S_READ;
              end
            end else begin
              state <= S_DIV_START;
            end
          end
        end
        S_PFX_ZERO: begin
          if (rsp_fire) begin
            character <= CHAR_X_LOWER;
            state     <= S_PFX_X;
          end
        end
        S_PFX_X: begin
          if (rsp_fire) begin
            rsp_valid <= 1'b0;
            state     <= S_READ;
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          // Digit from the store is available now; present it.
          rsp_valid  <= 1'b1;
          character  <= digit_char(ram_rdata, upper_q);
          last       <= (emit_index + CNT_W'(1) == digit_count);
          empty_res  <= 1'b0;
          bad_base   <= 1'b0;
          emit_index <= emit_index + CNT_W'(1);
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (rsp_fire) begin
            rsp_valid <= 1'b0;
            state     <= last ? S_IDLE : S_READ;
          end
        end
        S_SINGLE: begin
          if (rsp_fire) begin
            rsp_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
